// File: src/qfc_pkg.sv
// ----------------------------------------------------------------------------
// qfc_pkg: shared types and constants for the quick-find connectivity core
// Holds the controller state type, result status codes, register index
// codes and the fixed field widths.
// ----------------------------------------------------------------------------
package qfc_pkg;

  // Field widths
  localparam int IN_W      = 10;   // object index on the input channel
  localparam int ID_OUT_W  = 10;   // group id on the result channel
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 11;   // object_count register
  localparam int DATA_W    = 32;   // configuration data bus
  localparam int PADDR_W   = 3;    // one register, byte addressed

  // Defaults
  localparam int              MAX_OBJECTS_DEF = 1024;
  localparam logic [CNT_W-1:0] OBJ_COUNT_RESET = 11'd1024;

  // Register index codes (paddr[2])
  localparam logic REG_OBJECT_COUNT = 1'b0;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_MERGED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONNECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,   // write identity into the group table
    S_IDLE,    // wait for start, read first object's group
    S_RD_Q,    // capture first group, read second object's group
    S_CMP,     // capture second group, compare
    S_SCAN     // walk the table and relabel
  } qfc_state_t;

endpackage

// File: src/qfc_ram.sv
// ----------------------------------------------------------------------------
// qfc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qfc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/quick_find_connectivity_core.sv
// ----------------------------------------------------------------------------
// quick_find_connectivity_core: quick-find connectivity engine
// Keeps one group id per object in a RAM and merges groups by relabeling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_first_object / in_second_object and raise start;
//   the pair transfers at a clock edge with start high and busy low.
//   Result channel: out_valid strobes for one cycle with out_status and
//   out_group_after. The receiver cannot stall; each result is taken as shown.
//   Outcomes: an index out of range is answered while busy stays low; an
//   already connected pair or a merge holds busy high until its result.
//   One item at a time; busy is high until the result is issued. The merge
//   walk is set by the single RAM read port: one entry is read and compared
//   by the shared id comparator per cycle, and rewritten if it matches.
//   Reset and any write of object_count start a clearing pass that writes
//   entry i = i for all MAX_OBJECTS entries, with busy high. Configuration
//   writes are taken at any time; pready is always high.
//   object_count is clamped to 1..MAX_OBJECTS when used.
// ----------------------------------------------------------------------------
module quick_find_connectivity_core #(
  parameter int MAX_OBJECTS = qfc_pkg::MAX_OBJECTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [qfc_pkg::IN_W-1:0]      in_first_object,
  input  logic [qfc_pkg::IN_W-1:0]      in_second_object,
  // result channel
  output logic                          out_valid,
  output logic [qfc_pkg::STATUS_W-1:0]  out_status,
  output logic [qfc_pkg::ID_OUT_W-1:0]  out_group_after,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qfc_pkg::PADDR_W-1:0]   paddr,
  input  logic [qfc_pkg::DATA_W-1:0]    pwdata,
  output logic [qfc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import qfc_pkg::*;

  // Table address / group id width, and a count width that can hold MAX_OBJECTS
  localparam int AW = $clog2(MAX_OBJECTS);
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  // Registers
  qfc_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    obj_cnt_r, obj_cnt_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       q_r, q_nxt;
  logic [AW-1:0]       pid_r, pid_nxt;
  logic [AW-1:0]       qid_r, qid_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;        // next entry to read in the walk
  logic                pend_r, pend_nxt;      // read data of the walk is due
  logic [AW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_OUT_W-1:0] out_group_r, out_group_nxt;

  // RAM interface
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [AW-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [AW-1:0] ram_rd_data;

  // Misc
  logic [CW-1:0] n_eff;
  logic          cfg_wr;
  logic          in_range;
  logic          id_match;
  logic          walk_issue;

  qfc_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_OBJECTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration port: write completes on the access phase; reads are direct
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OBJECT_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OBJECT_COUNT) begin
      prdata = DATA_W'(obj_cnt_r);
    end
  end

  // Effective object count: clamp to 1..MAX_OBJECTS
  always_comb begin
    if (obj_cnt_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(obj_cnt_r) > MAX_OBJECTS) begin
      n_eff = CW'(MAX_OBJECTS);
    end else begin
      n_eff = CW'(obj_cnt_r);
    end
  end

  assign in_range = (32'(in_first_object) < 32'(n_eff)) &&
                    (32'(in_second_object) < 32'(n_eff));

  // Shared id comparator: pid against the RAM read data (qid, then each entry)
  assign id_match   = (ram_rd_data == pid_r);
  assign walk_issue = (idx_r < n_eff);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    obj_cnt_nxt    = obj_cnt_r;
    clr_nxt        = clr_r;
    q_nxt          = q_r;
    pid_nxt        = pid_r;
    qid_nxt        = qid_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    scan_addr_nxt  = scan_addr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_group_nxt  = out_group_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = clr_r;
    ram_wr_data    = clr_r;
    ram_rd_addr    = q_r;

    case (state_r)
      S_CLEAR: begin
        // write identity, one entry per cycle
        ram_wr_en = 1'b1;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_OBJECTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // present p's address so its group is out the next cycle
        ram_rd_addr = AW'(in_first_object);
        if (start) begin
          if (!in_range) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_RANGE;
            out_group_nxt  = '0;
          end else begin
            q_nxt     = AW'(in_second_object);
            state_nxt = S_RD_Q;
          end
        end
      end
      S_RD_Q: begin
        pid_nxt     = ram_rd_data;
        ram_rd_addr = q_r;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        qid_nxt = ram_rd_data;
        if (id_match) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CONNECTED;
          out_group_nxt  = ID_OUT_W'(ram_rd_data);
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // read entry idx; compare it in the next cycle and rewrite it on a match
        ram_rd_addr = idx_r[AW-1:0];
        if (walk_issue) begin
          idx_nxt       = idx_r + CW'(1);
          pend_nxt      = 1'b1;
          scan_addr_nxt = idx_r[AW-1:0];
        end
        ram_wr_addr = scan_addr_r;
        ram_wr_data = qid_r;
        ram_wr_en   = pend_r && id_match;
        if (!walk_issue && !pend_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MERGED;
          out_group_nxt  = ID_OUT_W'(qid_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    // object_count write: take the value and rebuild the identity table
    if (cfg_wr) begin
      obj_cnt_nxt = pwdata[CNT_W-1:0];
      state_nxt   = S_CLEAR;
      clr_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      obj_cnt_r   <= OBJ_COUNT_RESET;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      obj_cnt_r   <= obj_cnt_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    pid_r        <= pid_nxt;
    qid_r        <= qid_nxt;
    idx_r        <= idx_nxt;
    scan_addr_r  <= scan_addr_nxt;
    out_status_r <= out_status_nxt;
    out_group_r  <= out_group_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_group_after = out_group_r;

endmodule

// File: src/qfc_checker.sv
// ----------------------------------------------------------------------------
// qfc_checker: port-level assertions for the quick-find connectivity core
// Watches the command, result and configuration ports; bound to the top.
// ----------------------------------------------------------------------------
module qfc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [qfc_pkg::STATUS_W-1:0] out_status,
  input logic [qfc_pkg::ID_OUT_W-1:0] out_group_after,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         pready,
  input logic [qfc_pkg::PADDR_W-1:0]  paddr
);

  import qfc_pkg::*;

  // Reset leaves the block clearing its table with no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("busy low or result shown right after reset");

  // An accepted item either answers at once or holds busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item neither answered nor held busy");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_MERGED || out_status == ST_CONNECTED ||
                   out_status == ST_RANGE))
    else $error("undefined status code");

  // A range error carries group 0
  a_range_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |-> out_group_after == '0)
    else $error("range error with nonzero group");

  // Writing object_count starts a rebuild of the table
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[2] == REG_OBJECT_COUNT |=> busy)
    else $error("object_count write did not start table rebuild");

endmodule

bind quick_find_connectivity_core qfc_checker u_qfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_group_after (out_group_after),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .pready          (pready),
  .paddr           (paddr)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quick_find_connectivity_core
// Sends object pairs through the start/busy channel and keeps its own
// quick-find group table. Each accepted pair is resolved against that table
// in transfer order. The monitor checks every out_valid strobe against the
// oldest predicted verdict. The object count register is written between
// phases, covering the clamped extremes, and read back over APB.
// ----------------------------------------------------------------------------
module testbench;
  import qfc_pkg::*;

  localparam int                 OBJ_SLOTS  = MAX_OBJECTS_DEF;
  localparam logic [PADDR_W-1:0] COUNT_ADDR = {REG_OBJECT_COUNT, 2'b00};

  typedef struct {
    logic [IN_W-1:0] first;
    logic [IN_W-1:0] second;
  } obj_pair_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_OUT_W-1:0] group;
  } join_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic            start = 1'b0;
  logic            busy;
  logic [IN_W-1:0] in_first_object = '0;
  logic [IN_W-1:0] in_second_object = '0;

  // result channel
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_OUT_W-1:0] out_group_after;

  // configuration port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Shadow state of the engine: group id per object and the count register.
  logic [ID_OUT_W-1:0] group_of [0:OBJ_SLOTS-1];
  logic [CNT_W-1:0]    object_count_shadow;

  obj_pair_t     pair_backlog[$];      // pairs waiting to be sent
  join_verdict_t predicted_joins[$];   // verdicts waiting for their strobe

  int unsigned mismatch_count = 0;
  int unsigned idle_left = 0;
  bit          steady_drive = 1'b0;    // no sender idling in the final phase

  quick_find_connectivity_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_object  (in_first_object),
    .in_second_object (in_second_object),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_group_after  (out_group_after),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Every object back in its own group, as after reset or a count write.
  function automatic void restore_identity();
    for (int i = 0; i < OBJ_SLOTS; i++) group_of[i] = ID_OUT_W'(i);
  endfunction

  // The register is used clamped to 1..OBJ_SLOTS: zero acts as one object.
  function automatic int unsigned live_objects();
    int unsigned n;
    n = object_count_shadow;
    if (n < 1) n = 1;
    if (n > OBJ_SLOTS) n = OBJ_SLOTS;
    return n;
  endfunction

  // Resolve one pair: flag a bad index, report an existing connection, or
  // relabel every member of p's group with q's group id.
  function automatic join_verdict_t join_objects(logic [IN_W-1:0] p, logic [IN_W-1:0] q);
    int unsigned         n;
    logic [ID_OUT_W-1:0] pid;
    logic [ID_OUT_W-1:0] qid;
    join_verdict_t       v;
    n = live_objects();
    if (p >= n || q >= n) begin
      v.status = ST_RANGE;
      v.group  = '0;
      return v;
    end
    pid = group_of[p];
    qid = group_of[q];
    if (pid == qid) begin
      v.status = ST_CONNECTED;
      v.group  = pid;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (group_of[i] == pid) group_of[i] = qid;
      end
      v.status = ST_MERGED;
      v.group  = qid;
    end
    return v;
  endfunction

  function automatic void log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, what);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present pairs from the backlog; a pair transfers at an edge with
  // start high and busy low. Hold start and the payload while busy is high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // Transfer happened at this edge: predict now so verdicts stay in order.
        predicted_joins.push_back(join_objects(in_first_object, in_second_object));
        void'(pair_backlog.pop_front());
      end
      if (idle_left != 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pair_backlog.size() != 0) begin
        if (!steady_drive && $urandom_range(0, 7) == 0) begin
          // Open an idle burst that starts with this edge.
          idle_left = $urandom_range(0, 9);
          start <= 1'b0;
        end else begin
          start            <= 1'b1;
          in_first_object  <= pair_backlog[0].first;
          in_second_object <= pair_backlog[0].second;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each strobe carries one result; match it with the oldest verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    join_verdict_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (predicted_joins.size() == 0) begin
        log_mismatch($sformatf("unexpected result status %0d group %0d",
                               out_status, out_group_after));
      end else begin
        want = predicted_joins.pop_front();
        if (out_status !== want.status)
          log_mismatch($sformatf("status expected %0d actual %0d",
                                 want.status, out_status));
        if (out_group_after !== want.group)
          log_mismatch($sformatf("group_after expected %0d actual %0d",
                                 want.group, out_group_after));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_pair(int unsigned p, int unsigned q);
    obj_pair_t pr;
    pr.first  = IN_W'(p);
    pr.second = IN_W'(q);
    pair_backlog.push_back(pr);
  endfunction

  // Mostly in-range pairs so that groups actually grow; the rest span the
  // whole index field and exercise the out-of-range flag.
  function automatic void queue_random_pairs(int unsigned count);
    int unsigned n;
    n = live_objects();
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) != 0)
        queue_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      else
        queue_pair($urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endfunction

  // Hold until every pair is sent and every verdict has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pair_backlog.size() != 0 || start || predicted_joins.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register updates at the
  // edge that ends the access cycle and a clearing pass begins.
  task automatic write_object_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    object_count_shadow = value;
    restore_identity();
  endtask

  // APB read: sample prdata at the edge that completes the access cycle.
  task automatic read_object_count();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= COUNT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_W'(object_count_shadow))
      log_mismatch($sformatf("object_count read expected %0d actual %0d",
                             object_count_shadow, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] phase_counts [0:7];
    phase_counts = '{11'd2, 11'd1, 11'd9, 11'd24, 11'd1024, 11'd64, 11'd3, 11'd100};
    phase_counts[7] = CNT_W'($urandom_range(4, 200));

    object_count_shadow = OBJ_COUNT_RESET;
    restore_identity();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Full table after reset: index extremes, a self pair, chained merges.
    queue_pair(0, 1023);      // merge, 0 joins 1023's group
    queue_pair(1023, 0);      // now connected
    queue_pair(5, 5);         // same object twice
    queue_pair(682, 341);     // alternating bit patterns
    queue_pair(341, 1023);    // merge into the big group
    queue_pair(682, 0);       // connected through relabeling
    wait_drained();
    read_object_count();

    // Count of zero acts as one object: only index 0 is legal.
    write_object_count(11'd0);
    read_object_count();
    queue_pair(0, 0);
    queue_pair(0, 1);
    queue_pair(1, 0);
    queue_pair(1023, 1023);
    wait_drained();

    // Largest register value clamps to the full table.
    write_object_count(11'h7ff);
    read_object_count();
    queue_pair(1023, 0);
    queue_pair(0, 1023);
    queue_pair(512, 512);
    queue_pair(1, 2);
    queue_pair(2, 1023);
    wait_drained();

    // Random phases; each pauses once midway until all verdicts are back.
    for (int ph = 0; ph < 8; ph++) begin
      write_object_count(phase_counts[ph]);
      if (ph == 7) steady_drive = 1'b1;
      queue_random_pairs(35);
      wait_drained();
      queue_random_pairs(35);
      wait_drained();
    end
    read_object_count();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && predicted_joins.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every pair a full-table merge).
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
